FILE: design/sbpq_pkg.sv
// shared types, sizes and codes for the stable bucket priority queue
`timescale 1ns / 1ps
package sbpq_pkg;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_pay;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [1:0]              t_status;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic highest_first;
    } t_ctrl;

endpackage

FILE: design/sbpq_cell.sv
// one slot of the sorted chain: holds a key and payload, shifts with its neighbors
`timescale 1ns / 1ps
module sbpq_cell (
    input  logic               i_clk,
    input  sbpq_pkg::t_ctrl    i_ctrl,
    input  logic               i_occ,
    input  sbpq_pkg::t_key     i_in_key,
    input  sbpq_pkg::t_pay     i_in_pay,
    input  logic               i_left_ahead,
    input  sbpq_pkg::t_key     i_left_key,
    input  sbpq_pkg::t_pay     i_left_pay,
    input  sbpq_pkg::t_key     i_right_key,
    input  sbpq_pkg::t_pay     i_right_pay,
    output sbpq_pkg::t_key     o_key,
    output sbpq_pkg::t_pay     o_pay,
    output logic               o_ahead
);
    import sbpq_pkg::*;

    t_key r_key, n_key;
    t_pay r_pay, n_pay;

    // stored entry keeps its place ahead of the incoming key
    assign o_ahead = i_occ && (i_ctrl.highest_first ? (r_key >= i_in_key)
                                                    : (r_key <= i_in_key));

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        if (i_ctrl.push && !o_ahead) begin
            if (i_left_ahead) begin
                n_key = i_in_key;
                n_pay = i_in_pay;
            end else begin
                n_key = i_left_key;
                n_pay = i_left_pay;
            end
        end else if (i_ctrl.pop) begin
            n_key = i_right_key;
            n_pay = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

FILE: design/stable_bucket_priority_queue.sv
// top level of the stable bucket priority queue: cell chain, count and result registers
`timescale 1ns / 1ps
// Priority queue of up to CAPACITY entries, each a key and a payload, held
// sorted in a row of cells whose first cell is the front. A push request
// (operation 0) is inserted behind every stored entry of equal or better key,
// so equal keys leave first in, first out; a pop request (operation 1) returns
// the front entry. The busy output is low whenever reset is released, a new
// request can be given on every cycle, and its result appears on the cycle
// right after acceptance, marked by o_result_valid for exactly one cycle. The
// receiver cannot stall; results must be captured when the strobe is high. All
// cells compare against the incoming key in parallel and shift by one place in
// the same cycle. A full queue refuses a push (status 1), an empty queue
// refuses a pop (status 2). highest_first selects largest-key-first ordering;
// a write to it is ignored while the queue holds entries.
module stable_bucket_priority_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  sbpq_pkg::t_key        i_priority_req,
    input  sbpq_pkg::t_pay        i_payload,
    // configuration
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    // result channel
    output logic                  o_result_valid,
    output logic                  o_popped_valid,
    output sbpq_pkg::t_key        o_popped_priority,
    output sbpq_pkg::t_pay        o_popped_payload,
    output sbpq_pkg::t_status     o_status,
    output logic                  o_now_empty,
    output sbpq_pkg::t_cnt        o_entry_count
);
    import sbpq_pkg::*;

    // control state
    t_cnt    r_count, n_count;
    logic    r_highest_first;
    logic    r_res_valid;
    // result payload
    logic    r_pop_valid, n_pop_valid;
    t_key    r_pop_key, n_pop_key;
    t_pay    r_pop_pay, n_pop_pay;
    t_status r_status, n_status;

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    t_ctrl   w_ctrl;

    // cell chain wiring
    t_key    w_key   [CAPACITY];
    t_pay    w_pay   [CAPACITY];
    logic    w_ahead [CAPACITY];

    // no request is taken while reset is held
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == t_cnt'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // the chain only moves on a request that changes the contents
    assign w_ctrl.push          = w_accept && (i_operation == OP_PUSH) && !w_full;
    assign w_ctrl.pop           = w_accept && (i_operation == OP_POP) && !w_empty;
    assign w_ctrl.highest_first = r_highest_first;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_lkey, w_rkey;
        t_pay w_lpay, w_rpay;
        logic w_lahead;

        if (g == 0) begin : g_first
            // front cell: nothing to its left, takes the new entry when its own is not ahead
            assign w_lkey   = '0;
            assign w_lpay   = '0;
            assign w_lahead = 1'b1;
        end else begin : g_mid
            assign w_lkey   = w_key[g-1];
            assign w_lpay   = w_pay[g-1];
            assign w_lahead = w_ahead[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // back cell empties on a pop; contents beyond the count are don't-care
            assign w_rkey = '0;
            assign w_rpay = '0;
        end else begin : g_inner
            assign w_rkey = w_key[g+1];
            assign w_rpay = w_pay[g+1];
        end

        sbpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (t_cnt'(g) < r_count),
            .i_in_key     (i_priority_req),
            .i_in_pay     (i_payload),
            .i_left_ahead (w_lahead),
            .i_left_key   (w_lkey),
            .i_left_pay   (w_lpay),
            .i_right_key  (w_rkey),
            .i_right_pay  (w_rpay),
            .o_key        (w_key[g]),
            .o_pay        (w_pay[g]),
            .o_ahead      (w_ahead[g])
        );
    end

    // next count and result of the accepted request
    always_comb begin
        n_count     = r_count;
        n_pop_valid = 1'b0;
        n_pop_key   = '0;
        n_pop_pay   = '0;
        n_status    = ST_OK;
        if (i_operation == OP_PUSH) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + t_cnt'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count     = r_count - t_cnt'(1);
                n_pop_valid = 1'b1;
                n_pop_key   = w_key[0];
                n_pop_pay   = w_pay[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_highest_first <= 1'b0;
            r_res_valid     <= 1'b0;
        end else begin
            r_res_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
            // ordering only changes while nothing is stored
            if (i_cfg_we && w_empty) begin
                r_highest_first <= i_cfg_wdata;
            end
        end
    end

    // result fields are held from the accepting edge for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_valid <= n_pop_valid;
            r_pop_key   <= n_pop_key;
            r_pop_pay   <= n_pop_pay;
            r_status    <= n_status;
        end
    end

    assign o_result_valid    = r_res_valid;
    assign o_popped_valid    = r_pop_valid;
    assign o_popped_priority = r_pop_key;
    assign o_popped_payload  = r_pop_pay;
    assign o_status          = r_status;
    assign o_entry_count     = r_count;
    assign o_now_empty       = (r_count == '0);

endmodule

FILE: design/sbpq_checker.sv
// port-level checks for the stable bucket priority queue, bound to the top level
`timescale 1ns / 1ps
module sbpq_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  o_result_valid,
    input  logic                  o_popped_valid,
    input  sbpq_pkg::t_status     o_status,
    input  logic                  o_now_empty,
    input  sbpq_pkg::t_cnt        o_entry_count
);
    import sbpq_pkg::*;

    // every accepted request gives a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_valid)
        else $error("accepted request without result");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_result_valid)
        else $error("result without request");

    // a returned entry always comes with status ok
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_popped_valid) |-> (o_status == ST_OK))
        else $error("popped entry with error status");

    // refused push only when full, refused pop only when empty
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            ((o_status != ST_FULL || o_entry_count == CNT_W'(CAPACITY)) &&
             (o_status != ST_EMPTY || o_now_empty)))
        else $error("refusal inconsistent with count");

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_now_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

bind stable_bucket_priority_queue sbpq_checker u_sbpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_popped_valid (o_popped_valid),
    .o_status       (o_status),
    .o_now_empty    (o_now_empty),
    .o_entry_count  (o_entry_count)
);
